>>> rtl/fifo_queue_with_search_defines.svh
// Assertion macros used by the port checker of the search queue.
// Depends on nothing; each use expects clk and rst_n in scope.
`ifndef FIFO_QUEUE_WITH_SEARCH_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define FQS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fqs assertion failed: same-cycle rule");

// Next-cycle implication, checked at each rising clock edge outside reset.
`define FQS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fqs assertion failed: next-cycle rule");

`endif

>>> rtl/fqs_pkg.sv
// Shared constants, codes and control structs of the search queue.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package fqs_pkg;

    // Default queue capacity.
    localparam int DEPTH_DEF = 64;

    // Field widths of one item and one result.
    localparam int FUNC_W    = 2;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 6;
    localparam int COUNT_W   = 7;
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOCATE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;   // accept an item and apply insert or remove
        logic issue;   // read the next held entry for the search
        logic load;    // move the finished result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_needed;  // incoming item is a locate on a non-empty queue
        logic last_issue;   // the entry read now is the last held one
    } sts_t;

endpackage

>>> rtl/fqs_ctrl.sv
// Controller state machine of the search queue.
// Depends on fqs_pkg for the command and status structs.
`timescale 1ns / 1ps

module fqs_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output fqs_pkg::cmd_t cmd,
    input  fqs_pkg::sts_t sts
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Commands decoded from the current state and the handshakes.
    always_comb
    begin
        cmd.start = (state_reg == ST_IDLE) && s_tvalid;
        cmd.issue = (state_reg == ST_SCAN);
        cmd.load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // Next state: a locate on a non-empty queue walks the entries, everything else goes straight to the result.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = sts.scan_needed ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (sts.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output register fills on load and drains when the item is taken.
    always_comb
    begin
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/fqs_dp.sv
// Datapath of the search queue: entry memory, pointers, scan and result.
// Depends on fqs_pkg for widths, codes and the command and status structs.
`timescale 1ns / 1ps

module fqs_dp
#(
    parameter int DEPTH = fqs_pkg::DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [fqs_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [fqs_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic [fqs_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [fqs_pkg::M_TUSER_W-1:0]   m_tuser,
    input  fqs_pkg::cmd_t                   cmd,
    output fqs_pkg::sts_t                   sts
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W:0]   DEPTH_S  = (CNT_W + 1)'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [fqs_pkg::VALUE_W-1:0] mem [DEPTH];

    logic [PTR_W-1:0]               front_reg;
    logic [CNT_W-1:0]               count_reg;
    logic [fqs_pkg::VALUE_W-1:0]    key_reg;
    logic                           search_reg;
    logic [fqs_pkg::STATUS_W-1:0]   status_reg;
    logic [PTR_W-1:0]               idx_reg;
    logic [PTR_W-1:0]               rd_ptr_reg;
    logic [fqs_pkg::VALUE_W-1:0]    rd_data_reg;
    logic [PTR_W-1:0]               cmp_pos_reg;
    logic                           cmp_vld_reg;
    logic                           found_reg;
    logic [PTR_W-1:0]               found_pos_reg;
    logic [fqs_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic [fqs_pkg::M_TUSER_W-1:0]  m_tuser_reg;
    logic [fqs_pkg::M_TDATA_W-1:0]  m_tdata_next;
    logic [fqs_pkg::M_TUSER_W-1:0]  m_tuser_next;

    logic [fqs_pkg::FUNC_W-1:0]  func;
    logic [fqs_pkg::VALUE_W-1:0] value;
    logic                        is_empty;
    logic                        is_full;
    logic [CNT_W:0]              tail_sum;
    logic [PTR_W-1:0]            tail;
    logic                        wr_en;
    logic                        pop;
    logic [31:0]                 pos_ext;
    logic [31:0]                 cnt_ext;

    assign func  = s_tuser[fqs_pkg::FUNC_W-1:0];
    assign value = s_tdata[fqs_pkg::VALUE_W-1:0];

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));

    // Tail slot: front plus count, wrapped once at the capacity.
    assign tail_sum = (CNT_W + 1)'(front_reg) + (CNT_W + 1)'(count_reg);
    assign tail     = (tail_sum >= DEPTH_S) ? PTR_W'(tail_sum - DEPTH_S) : PTR_W'(tail_sum);

    assign wr_en = cmd.start && (func == fqs_pkg::FUNC_INSERT) && !is_full;
    assign pop   = cmd.start && (func == fqs_pkg::FUNC_REMOVE) && !is_empty;

    // Status toward the controller.
    always_comb
    begin
        sts.scan_needed = (func == fqs_pkg::FUNC_LOCATE) && !is_empty;
        sts.last_issue  = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));
    end

    // Entry memory: one write port for inserts, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail] <= value;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // Queue pointers and the held-entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (wr_en)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
        else if (pop)
        begin
            front_reg <= (front_reg == LAST_PTR) ? '0 : front_reg + PTR_W'(1);
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Item capture and the immediate status of insert and remove.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg    <= value;
            search_reg <= (func == fqs_pkg::FUNC_LOCATE);
            if ((func == fqs_pkg::FUNC_INSERT) && is_full)
            begin
                status_reg <= fqs_pkg::STAT_FULL;
            end
            else if ((func == fqs_pkg::FUNC_REMOVE) && is_empty)
            begin
                status_reg <= fqs_pkg::STAT_EMPTY;
            end
            else
            begin
                status_reg <= fqs_pkg::STAT_DONE;
            end
        end
    end

    // Scan address walk: one entry read per cycle from the front onward.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            idx_reg    <= '0;
            rd_ptr_reg <= front_reg;
        end
        else if (cmd.issue)
        begin
            idx_reg    <= idx_reg + PTR_W'(1);
            rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
    end

    // Compare stage in the cycle after the read; a later match replaces an earlier one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= cmd.issue;
            if (cmd.start)
            begin
                found_reg <= 1'b0;
            end
            else if (cmp_vld_reg && (rd_data_reg == key_reg))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            cmp_pos_reg <= idx_reg;
        end
        if (cmp_vld_reg && (rd_data_reg == key_reg))
        begin
            found_pos_reg <= cmp_pos_reg;
        end
    end

    // Result assembly from the count after the operation.
    assign pos_ext = 32'(found_pos_reg);
    assign cnt_ext = 32'(count_reg);

    always_comb
    begin
        m_tdata_next = {1'b0, is_full, is_empty, cnt_ext[fqs_pkg::COUNT_W-1:0],
                        found_reg ? pos_ext[fqs_pkg::POS_W-1:0] : fqs_pkg::POS_W'(0)};
        if (search_reg)
        begin
            m_tuser_next = found_reg ? fqs_pkg::STAT_DONE : fqs_pkg::STAT_NOTFOUND;
        end
        else
        begin
            m_tuser_next = status_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

>>> rtl/fifo_queue_with_search.sv
// Search queue: a bounded FIFO of signed 32-bit values with insert, remove
// and locate. Insert, remove and any unused operation code answer without a
// scan, and the next item can be taken in the same cycle that the answer
// appears. A locate reads the held entries one per cycle through the single
// read port of the entry memory, and the next item can be taken in the same
// cycle that its answer appears. A finished result waits in the output
// register while the next item is taken. Reset needs no clearing pass: only
// entries that an insert wrote are ever read.
//
// Top level: ties the controller to the datapath. Depends on fqs_pkg,
// fqs_ctrl and fqs_dp.
`timescale 1ns / 1ps

module fifo_queue_with_search
#(
    parameter int DEPTH = fqs_pkg::DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fqs_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] value
    input  logic [fqs_pkg::S_TUSER_W-1:0]   s_tuser,   // [1:0] func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fqs_pkg::M_TDATA_W-1:0]   m_tdata,   // [5:0] position, [12:6] entry_count,
                                                       // [13] is_empty, [14] is_full, [15] zero
    output logic [fqs_pkg::M_TUSER_W-1:0]   m_tuser    // [1:0] status
);

    fqs_pkg::cmd_t cmd;
    fqs_pkg::sts_t sts;

    // Sequencer for one item at a time.
    fqs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Memory, pointers, scan compare and output register.
    fqs_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

>>> rtl/fqs_checker.sv
// Port-level checker of the search queue, bound to the top level.
// Depends on fqs_pkg and the assertion macros in the defines header.
`timescale 1ns / 1ps
`include "fifo_queue_with_search_defines.svh"

module fqs_port_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [fqs_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [fqs_pkg::M_TUSER_W-1:0]   m_tuser
);

    // An empty queue reports a zero count.
    `FQS_ASSERT_NOW(a_empty_count, m_tvalid && m_tdata[13], m_tdata[12:6] == 7'd0)

    // Empty and full never show together.
    `FQS_ASSERT_NOW(a_empty_full, m_tvalid, !(m_tdata[13] && m_tdata[14]))

    // A failed search reports position zero.
    `FQS_ASSERT_NOW(a_nf_pos, m_tvalid && m_tuser == fqs_pkg::STAT_NOTFOUND, m_tdata[5:0] == '0)

    // A stalled result holds.
    `FQS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // The block works on one item at a time, so the input closes after each accepted item.
    `FQS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

endmodule

bind fifo_queue_with_search fqs_port_checker u_fqs_checker (.*);
